/* hdl/rcu_pkg.sv */
// Shared types, constants and helpers for the radix converter unit.
// Used by rcu_divider and radix_converter_unit; no dependencies.

package rcu_pkg;

   // Field and register widths
   localparam int NUM_WIDTH  = 31;
   localparam int RADIX_WIDTH = 4;
   localparam int CSR_INDEX_WIDTH = 1;

   // Radix limits and the fixed decimal radix
   localparam logic [RADIX_WIDTH-1:0] RADIX_MIN = 4'd2;
   localparam logic [RADIX_WIDTH-1:0] RADIX_DEC = 4'd10;

   // Saturation limit of a result
   localparam logic [NUM_WIDTH-1:0] RESULT_MAX = 31'h7FFF_FFFF;

   // Largest decimal place weight below the saturation limit (10^9)
   localparam int WEIGHT_WIDTH = 30;
   localparam logic [WEIGHT_WIDTH-1:0] WEIGHT_LAST = 30'd1000000000;

   // Configuration register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FROM_BASE = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TO_BASE   = 1'b1;

   // Divider geometry: quotient bits per cycle and cycles per division
   localparam int DIV_WIDTH  = 32;
   localparam int DIV_STEP   = 8;
   localparam int DIV_CYCLES = DIV_WIDTH / DIV_STEP;
   localparam int DIV_CNT_WIDTH = $clog2(DIV_CYCLES);
   localparam logic [DIV_CNT_WIDTH-1:0] DIV_CNT_LAST = DIV_CNT_WIDTH'(DIV_CYCLES - 1);

   // Sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_DEC_CHK,
      S_DEC_WAIT,
      S_TGT_CHK,
      S_TGT_WAIT,
      S_FINISH
   } state_type;

   // Divider request and response
   typedef struct packed {
      logic                   start;
      logic [DIV_WIDTH-1:0]   dividend;
      logic [RADIX_WIDTH-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                   done;
      logic [DIV_WIDTH-1:0]   quotient;
      logic [RADIX_WIDTH-1:0] remainder;
   } div_rsp_type;

   // Force a radix register value into 2..10
   function automatic logic [RADIX_WIDTH-1:0] clamp_radix(input logic [RADIX_WIDTH-1:0] r);
      logic [RADIX_WIDTH-1:0] c;
      if (r < RADIX_MIN) begin
         c = RADIX_MIN;
      end else if (r > RADIX_DEC) begin
         c = RADIX_DEC;
      end else begin
         c = r;
      end
      return c;
   endfunction

endpackage

/* hdl/rcu_divider.sv */
// Iterative divider by a small radix (2..10), several quotient bits per cycle.
// Depends on rcu_pkg for geometry and the request/response structs.

module rcu_divider (
   input  logic                clock,
   input  logic                reset,
   input  rcu_pkg::div_req_type div_req,
   output rcu_pkg::div_rsp_type div_rsp
);

   logic                                busy_ff, busy_in;
   logic                                done_ff, done_in;
   logic [rcu_pkg::DIV_CNT_WIDTH-1:0]   cnt_ff, cnt_in;
   logic [rcu_pkg::DIV_WIDTH-1:0]       work_ff, work_in;
   logic [rcu_pkg::RADIX_WIDTH-1:0]     rem_ff, rem_in;
   logic [rcu_pkg::RADIX_WIDTH-1:0]     divisor_ff, divisor_in;

   // Restoring division over one slice of dividend bits
   always_comb begin
      logic [rcu_pkg::RADIX_WIDTH:0] r;
      logic [rcu_pkg::DIV_WIDTH-1:0] w;
      r = {1'b0, rem_ff};
      w = work_ff;
      for (int i = 0; i < rcu_pkg::DIV_STEP; i++) begin
         r = {r[rcu_pkg::RADIX_WIDTH-1:0], w[rcu_pkg::DIV_WIDTH-1]};
         w = {w[rcu_pkg::DIV_WIDTH-2:0], 1'b0};
         if (r >= {1'b0, divisor_ff}) begin
            r = r - {1'b0, divisor_ff};
            w[0] = 1'b1;
         end
      end

      busy_in    = busy_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      work_in    = work_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;

      if (div_req.start) begin
         busy_in    = 1'b1;
         cnt_in     = '0;
         work_in    = div_req.dividend;
         rem_in     = '0;
         divisor_in = div_req.divisor;
      end else if (busy_ff) begin
         work_in = w;
         rem_in  = r[rcu_pkg::RADIX_WIDTH-1:0];
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == rcu_pkg::DIV_CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Operands and partial results
   always_ff @(posedge clock) begin
      work_ff    <= work_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = work_ff;
   assign div_rsp.remainder = rem_ff;

   // A new division never starts over one in flight
   assert property (@(posedge clock) disable iff (reset) div_req.start |-> !busy_ff)
      else $error("divider started while busy");

   // The finished remainder is below the divisor
   assert property (@(posedge clock) disable iff (reset) done_ff |-> (rem_ff < divisor_ff))
      else $error("divider remainder not below divisor");

   // Done follows the last slice of a division
   assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !div_req.start && cnt_ff == rcu_pkg::DIV_CNT_LAST) |=> done_ff)
      else $error("divider done missing after last slice");

endmodule

/* hdl/radix_converter_unit.sv */
// Radix converter: reads a decimal-coded number in one radix, writes it
// decimal-coded in another. Depends on rcu_pkg and rcu_divider.
//
// Usage:
//  - csr_ port: write from_base (index 0) or to_base (index 1) with
//    csr_write_enable; values are clamped to 2..10. Write only while idle.
//  - req_ channel: one number per transfer; req_stall is high while an
//    item is being converted, so one item is in work at a time.
//  - rsp_ channel: result value and overflow flag, held in an output
//    register until the receiver takes it. A new request is accepted while
//    a result still waits; the next result waits in the sequencer until the
//    output register is free.
//  - Timing: equal radices skip the divider; the request goes straight to the
//    finish state and on to the output register. Otherwise each digit, input
//    decimal digit or output target digit, takes one division on the shared
//    8-bit-per-cycle divider (issue, 4 slices, retire). An input has at most
//    10 decimal digits, an output at most 31 target digits. The sequencer goes
//    idle as the result is loaded into the output register, then takes requests.
//  - Reset: both radices return to 10, the sequencer goes idle and no
//    result is pending.

module radix_converter_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [rcu_pkg::NUM_WIDTH-1:0]        req_number,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [rcu_pkg::NUM_WIDTH-1:0]        rsp_result_value,
   output logic                                 rsp_overflow,
   input  logic                                 csr_write_enable,
   input  logic [rcu_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [rcu_pkg::RADIX_WIDTH-1:0]      csr_write_data
);

   rcu_pkg::state_type                  state_ff, state_in;
   logic [rcu_pkg::RADIX_WIDTH-1:0]     from_base_ff, from_base_in;
   logic [rcu_pkg::RADIX_WIDTH-1:0]     to_base_ff, to_base_in;
   logic [rcu_pkg::NUM_WIDTH-1:0]       num_ff, num_in;
   logic [rcu_pkg::NUM_WIDTH-1:0]       value_ff, value_in;
   logic [rcu_pkg::DIV_WIDTH-1:0]       weight_ff, weight_in;
   logic [rcu_pkg::WEIGHT_WIDTH-1:0]    tw_ff, tw_in;
   logic                                tw_over_ff, tw_over_in;
   logic [rcu_pkg::NUM_WIDTH-1:0]       acc_ff, acc_in;
   logic                                ovf_ff, ovf_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [rcu_pkg::NUM_WIDTH-1:0]       rsp_value_ff, rsp_value_in;
   logic                                rsp_ovf_ff, rsp_ovf_in;

   logic [rcu_pkg::RADIX_WIDTH-1:0]     fb, tb;
   logic                                req_xfer, rsp_load;
   rcu_pkg::div_req_type                div_req;
   rcu_pkg::div_rsp_type                div_rsp;

   logic [rcu_pkg::DIV_WIDTH+rcu_pkg::RADIX_WIDTH-1:0]    dec_term, dec_weight;
   logic [rcu_pkg::WEIGHT_WIDTH+rcu_pkg::RADIX_WIDTH-1:0] tgt_term, tw_next;
   logic [rcu_pkg::WEIGHT_WIDTH+rcu_pkg::RADIX_WIDTH:0]   tgt_sum;

   rcu_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign fb = rcu_pkg::clamp_radix(from_base_ff);
   assign tb = rcu_pkg::clamp_radix(to_base_ff);

   assign req_stall = (state_ff != rcu_pkg::S_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_load  = (state_ff == rcu_pkg::S_FINISH) && (!rsp_valid_ff || !rsp_stall);

   // Configuration writes
   always_comb begin
      from_base_in = from_base_ff;
      to_base_in   = to_base_ff;
      if (csr_write_enable) begin
         case (csr_index)
            rcu_pkg::CSR_FROM_BASE: from_base_in = csr_write_data;
            rcu_pkg::CSR_TO_BASE:   to_base_in   = csr_write_data;
            default: ;
         endcase
      end
   end

   // Digit products: source weighting, target decimal placement
   assign dec_term   = div_rsp.remainder * weight_ff;
   assign dec_weight = weight_ff * fb;
   assign tgt_term   = div_rsp.remainder * tw_ff;
   assign tgt_sum    = {{(rcu_pkg::WEIGHT_WIDTH + rcu_pkg::RADIX_WIDTH + 1
                          - rcu_pkg::NUM_WIDTH){1'b0}}, acc_ff}
                     + {1'b0, tgt_term};
   assign tw_next    = tw_ff * rcu_pkg::RADIX_DEC;

   // Sequencer: next state and datapath
   always_comb begin
      state_in   = state_ff;
      num_in     = num_ff;
      value_in   = value_ff;
      weight_in  = weight_ff;
      tw_in      = tw_ff;
      tw_over_in = tw_over_ff;
      acc_in     = acc_ff;
      ovf_in     = ovf_ff;
      div_req.start    = 1'b0;
      div_req.dividend = {1'b0, num_ff};
      div_req.divisor  = rcu_pkg::RADIX_DEC;

      case (state_ff)
         rcu_pkg::S_IDLE: begin
            if (req_xfer) begin
               num_in     = req_number;
               value_in   = '0;
               weight_in  = rcu_pkg::DIV_WIDTH'(1);
               tw_in      = rcu_pkg::WEIGHT_WIDTH'(1);
               tw_over_in = 1'b0;
               acc_in     = '0;
               ovf_in     = 1'b0;
               if (fb == tb) begin
                  acc_in   = req_number;
                  state_in = rcu_pkg::S_FINISH;
               end else begin
                  state_in = rcu_pkg::S_DEC_CHK;
               end
            end
         end

         // Peel decimal digits off the input
         rcu_pkg::S_DEC_CHK: begin
            if (num_ff == '0) begin
               state_in = rcu_pkg::S_TGT_CHK;
            end else begin
               div_req.start = 1'b1;
               state_in      = rcu_pkg::S_DEC_WAIT;
            end
         end

         rcu_pkg::S_DEC_WAIT: begin
            if (div_rsp.done) begin
               num_in    = div_rsp.quotient[rcu_pkg::NUM_WIDTH-1:0];
               value_in  = value_ff + dec_term[rcu_pkg::NUM_WIDTH-1:0];
               weight_in = dec_weight[rcu_pkg::DIV_WIDTH-1:0];
               state_in  = rcu_pkg::S_DEC_CHK;
            end
         end

         // Peel target-radix digits off the value
         rcu_pkg::S_TGT_CHK: begin
            div_req.dividend = {1'b0, value_ff};
            div_req.divisor  = tb;
            if (value_ff == '0) begin
               state_in = rcu_pkg::S_FINISH;
            end else begin
               div_req.start = 1'b1;
               state_in      = rcu_pkg::S_TGT_WAIT;
            end
         end

         rcu_pkg::S_TGT_WAIT: begin
            div_req.dividend = {1'b0, value_ff};
            div_req.divisor  = tb;
            if (div_rsp.done) begin
               value_in = div_rsp.quotient[rcu_pkg::NUM_WIDTH-1:0];
               // place the digit, saturating on overflow
               if (div_rsp.remainder != '0 && !ovf_ff) begin
                  if (tw_over_ff ||
                      tgt_sum > {{(rcu_pkg::WEIGHT_WIDTH + rcu_pkg::RADIX_WIDTH + 1
                                   - rcu_pkg::NUM_WIDTH){1'b0}}, rcu_pkg::RESULT_MAX}) begin
                     ovf_in = 1'b1;
                     acc_in = rcu_pkg::RESULT_MAX;
                  end else begin
                     acc_in = tgt_sum[rcu_pkg::NUM_WIDTH-1:0];
                  end
               end
               // next decimal place; past 10^9 every place overflows
               if (!tw_over_ff) begin
                  if (tw_ff == rcu_pkg::WEIGHT_LAST) begin
                     tw_over_in = 1'b1;
                  end else begin
                     tw_in = tw_next[rcu_pkg::WEIGHT_WIDTH-1:0];
                  end
               end
               state_in = rcu_pkg::S_TGT_CHK;
            end
         end

         rcu_pkg::S_FINISH: begin
            if (rsp_load) begin
               state_in = rcu_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = rcu_pkg::S_IDLE;
         end
      endcase
   end

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = acc_ff;
         rsp_ovf_in   = ovf_ff;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rcu_pkg::S_IDLE;
         from_base_ff <= rcu_pkg::RADIX_DEC;
         to_base_ff   <= rcu_pkg::RADIX_DEC;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         from_base_ff <= from_base_in;
         to_base_ff   <= to_base_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      num_ff       <= num_in;
      value_ff     <= value_in;
      weight_ff    <= weight_in;
      tw_ff        <= tw_in;
      tw_over_ff   <= tw_over_in;
      acc_ff       <= acc_in;
      ovf_ff       <= ovf_in;
      rsp_value_ff <= rsp_value_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_overflow     = rsp_ovf_ff;

   // An overflowed result is always saturated
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ovf_ff) |-> (rsp_value_ff == rcu_pkg::RESULT_MAX))
      else $error("overflow without saturated result");

   // Divider completions arrive only while the sequencer waits for them
   assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == rcu_pkg::S_DEC_WAIT || state_ff == rcu_pkg::S_TGT_WAIT))
      else $error("divider done outside a wait state");

   // A decimal digit is always below ten
   assert property (@(posedge clock) disable iff (reset)
      (div_rsp.done && state_ff == rcu_pkg::S_DEC_WAIT) |-> (div_rsp.remainder < rcu_pkg::RADIX_DEC))
      else $error("decimal digit out of range");

   // An accepted request always leaves the idle state
   assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (state_ff != rcu_pkg::S_IDLE))
      else $error("request accepted but sequencer stayed idle");

endmodule
